// ===== design/vac_pkg.sv =====
// ----------------------------------------------------------------------------
// vac_pkg
// Shared defaults and sizes for the vector angle cosine block.
// ----------------------------------------------------------------------------
`default_nettype none

package vac_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int FRACTION_BITS_DEF  = 15;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // cosine lanes: between a and b, then a against x, y, z
    localparam int LANES     = 4;
    localparam int LANE_BETW = 0;
    localparam int LANE_X    = 1;
    localparam int LANE_Y    = 2;
    localparam int LANE_Z    = 3;

endpackage

`default_nettype wire

// ===== design/vector_angle_cosine.sv =====
// ----------------------------------------------------------------------------
// vector_angle_cosine
// Cosine of the angle between two 3-axis vectors, direction cosines of the
// first vector and its length.
// ----------------------------------------------------------------------------
//  channel   dir  ports                 word contents
//  s_        in   tvalid tready tdata   a_x a_y a_z b_x b_y b_z
//  m_        out  tvalid tready tdata   cos_between cos_to_x/y/z length_a zero_length
//
//  one word per cycle sustained while m_tready is high; pipeline of 2 front,
//  1 queue, 2 product, max(FRACTION_BITS+1, COMPONENT_BITS) quotient/root
//  stages and 1 output stage, the quotient/root part working one bit per stage
//  synchronous active-low reset clears all valid flags and the queue
//  m_tready low with a valid output word freezes the back pipeline; the queue then absorbs the front
// ----------------------------------------------------------------------------
`default_nettype none

module vector_angle_cosine #(
    parameter int COMPONENT_BITS = vac_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = vac_pkg::FRACTION_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, zero pad
    input  wire logic [((6*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // cos_between, cos_to_x, cos_to_y, cos_to_z, length_a, zero_length, zero pad
    output logic [((4*(FRACTION_BITS+1)+COMPONENT_BITS+1+7)/8)*8-1:0] m_tdata
);

    localparam int IW = 12 * COMPONENT_BITS + 4;

    logic          fq_valid, fq_ready;
    logic [IW-1:0] fq_data;
    logic          qb_valid, qb_ready;
    logic [IW-1:0] qb_data;

    vac_front #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    vac_queue #(
        .DATA_BITS(IW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    vac_back #(
        .COMPONENT_BITS(COMPONENT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_data   (qb_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// ===== design/vac_front.sv =====
// ----------------------------------------------------------------------------
// vac_front
// Takes the vector pair, forms squares and dot terms, then squared lengths, the
// dot product magnitude and sign, and passes on the squares and signs of a.
// ----------------------------------------------------------------------------
`default_nettype none

module vac_front #(
    parameter int COMPONENT_BITS = vac_pkg::COMPONENT_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [((6*COMPONENT_BITS+7)/8)*8-1:0]  s_tdata,
    output logic                                        q_valid,
    input  wire logic                                   q_ready,
    output logic [12*COMPONENT_BITS+3:0]                q_data
);

    localparam int CB = COMPONENT_BITS;
    localparam int LW = 2 * CB;

    typedef struct packed {
        logic [LW-1:0] la;
        logic [LW-1:0] lb;
        logic [LW-1:0] mag;
        logic          dneg;
        logic [LW-1:0] ax2;
        logic [LW-1:0] ay2;
        logic [LW-1:0] az2;
        logic          axn;
        logic          ayn;
        logic          azn;
    } item_t;

    logic signed [CB-1:0] av [3];
    logic signed [CB-1:0] bv [3];

    logic              v1_reg, v1_next;
    logic              v2_reg, v2_next;
    logic [LW-1:0]     sqa_reg [3];
    logic [LW-1:0]     sqb_reg [3];
    logic signed [LW-1:0] pr_reg [3];
    logic [2:0]        an_reg;
    item_t             item_reg, item_next;
    logic              adv;

    logic signed [LW:0] dot;

    for (genvar i = 0; i < 3; i++) begin : g_unpack
        assign av[i] = $signed(s_tdata[i*CB +: CB]);
        assign bv[i] = $signed(s_tdata[(i+3)*CB +: CB]);
    end

    assign adv      = !v2_reg || q_ready;
    assign s_tready = adv;

    always_comb begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        if (adv) begin
            v1_next = s_tvalid;
            v2_next = v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // squares and component products
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                sqa_reg[i] <= LW'(av[i]) * LW'(av[i]);
                sqb_reg[i] <= LW'(bv[i]) * LW'(bv[i]);
                pr_reg[i]  <= LW'(av[i]) * LW'(bv[i]);
                an_reg[i]  <= av[i][CB-1];
            end
        end
    end

    always_comb begin
        dot = (LW+1)'(pr_reg[0]) + (LW+1)'(pr_reg[1]) + (LW+1)'(pr_reg[2]);
        item_next.la   = sqa_reg[0] + sqa_reg[1] + sqa_reg[2];
        item_next.lb   = sqb_reg[0] + sqb_reg[1] + sqb_reg[2];
        item_next.dneg = dot[LW];
        item_next.mag  = dot[LW] ? LW'(-dot) : LW'(dot);
        item_next.ax2  = sqa_reg[0];
        item_next.ay2  = sqa_reg[1];
        item_next.az2  = sqa_reg[2];
        item_next.axn  = an_reg[0];
        item_next.ayn  = an_reg[1];
        item_next.azn  = an_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= item_next;
        end
    end

    assign q_valid = v2_reg;
    assign q_data  = item_reg;

endmodule

`default_nettype wire

// ===== design/vac_queue.sv =====
// ----------------------------------------------------------------------------
// vac_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module vac_queue #(
    parameter int DATA_BITS = 12 * vac_pkg::COMPONENT_BITS_DEF + 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [DATA_BITS-1:0] in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [DATA_BITS-1:0]      out_data
);

    logic [DATA_BITS-1:0]        mem [vac_pkg::QUEUE_DEPTH];
    logic [vac_pkg::QPTR_W-1:0]  wr_reg, wr_next;
    logic [vac_pkg::QPTR_W-1:0]  rd_reg, rd_next;
    logic [vac_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        push, pop;

    assign in_ready  = cnt_reg != vac_pkg::QCNT_W'(vac_pkg::QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/vac_back.sv =====
// ----------------------------------------------------------------------------
// vac_back
// Wide products, then one quotient bit per stage for the four cosine lanes
// and one root bit per stage for the length, then output formatting.
// ----------------------------------------------------------------------------
`default_nettype none

module vac_back #(
    parameter int COMPONENT_BITS = vac_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = vac_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       q_valid,
    output logic                            q_ready,
    input  wire logic [12*COMPONENT_BITS+3:0] q_data,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [((4*(FRACTION_BITS+1)+COMPONENT_BITS+1+7)/8)*8-1:0] m_tdata
);

    localparam int CB  = COMPONENT_BITS;
    localparam int F   = FRACTION_BITS;
    localparam int LW  = 2 * CB;
    localparam int PPW = 3 * CB;
    localparam int PW  = 4 * CB;
    localparam int WW  = 4 * CB + 2 * F + 4;
    localparam int SQW = 2 * CB + 1;
    localparam int QW  = F + 1;
    localparam int K   = (F + 1 > CB) ? F + 1 : CB;
    localparam int OW  = 4 * QW + CB + 1;
    localparam int MW  = ((OW + 7) / 8) * 8;

    typedef struct packed {
        logic [LW-1:0] la;
        logic [LW-1:0] lb;
        logic [LW-1:0] mag;
        logic          dneg;
        logic [LW-1:0] ax2;
        logic [LW-1:0] ay2;
        logic [LW-1:0] az2;
        logic          axn;
        logic          ayn;
        logic          azn;
    } item_t;

    typedef struct packed {
        logic [WW-1:0] r;
        logic [WW-1:0] t;
        logic [WW-1:0] p;
        logic [QW-1:0] q;
        logic          z;
        logic          n;
    } lane_t;

    typedef struct packed {
        lane_t [vac_pkg::LANES-1:0] e;
        logic [SQW-1:0]             v;
        logic [SQW-1:0]             res;
    } stage_t;

    item_t          qi;
    logic           adv;
    logic           b1v_reg, b1v_next;
    item_t          it1_reg;
    logic [PPW-1:0] pla_reg, pha_reg, plm_reg, phm_reg;
    logic [PW-1:0]  prod_ab, prod_dd;
    stage_t         st0_next;
    stage_t         st_reg  [K+1];
    stage_t         st_next [K];
    logic [K:0]     vld_reg, vld_next;
    logic           mv_reg, mv_next;
    logic [MW-1:0]  md_reg, md_next;

    assign qi      = q_data;
    assign adv     = !mv_reg || m_tready;
    assign q_ready = adv;

    always_comb begin
        b1v_next = b1v_reg;
        vld_next = vld_reg;
        mv_next  = mv_reg;
        if (adv) begin
            b1v_next = q_valid;
            vld_next = {vld_reg[K-1:0], b1v_reg};
            mv_next  = vld_reg[K];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1v_reg <= 1'b0;
            vld_reg <= '0;
            mv_reg  <= 1'b0;
        end else begin
            b1v_reg <= b1v_next;
            vld_reg <= vld_next;
            mv_reg  <= mv_next;
        end
    end

    // partial products of the two wide multiplications
    always_ff @(posedge aclk) begin
        if (adv) begin
            it1_reg <= qi;
            pla_reg <= PPW'(qi.la[CB-1:0]) * PPW'(qi.lb);
            pha_reg <= PPW'(qi.la[LW-1:CB]) * PPW'(qi.lb);
            plm_reg <= PPW'(qi.mag[CB-1:0]) * PPW'(qi.mag);
            phm_reg <= PPW'(qi.mag[LW-1:CB]) * PPW'(qi.mag);
        end
    end

    assign prod_ab = PW'(pla_reg) + (PW'(pha_reg) << CB);
    assign prod_dd = PW'(plm_reg) + (PW'(phm_reg) << CB);

    // lane setup: find largest q with q^2 * p <= r
    always_comb begin
        st0_next = '0;
        st0_next.e[vac_pkg::LANE_BETW].r = WW'(prod_dd) << (2 * F);
        st0_next.e[vac_pkg::LANE_BETW].p = WW'(prod_ab);
        st0_next.e[vac_pkg::LANE_BETW].z = (it1_reg.la == '0) || (it1_reg.lb == '0);
        st0_next.e[vac_pkg::LANE_BETW].n = it1_reg.dneg;
        st0_next.e[vac_pkg::LANE_X].r    = WW'(it1_reg.ax2) << (2 * F);
        st0_next.e[vac_pkg::LANE_X].p    = WW'(it1_reg.la);
        st0_next.e[vac_pkg::LANE_X].z    = it1_reg.ax2 == '0;
        st0_next.e[vac_pkg::LANE_X].n    = it1_reg.axn;
        st0_next.e[vac_pkg::LANE_Y].r    = WW'(it1_reg.ay2) << (2 * F);
        st0_next.e[vac_pkg::LANE_Y].p    = WW'(it1_reg.la);
        st0_next.e[vac_pkg::LANE_Y].z    = it1_reg.ay2 == '0;
        st0_next.e[vac_pkg::LANE_Y].n    = it1_reg.ayn;
        st0_next.e[vac_pkg::LANE_Z].r    = WW'(it1_reg.az2) << (2 * F);
        st0_next.e[vac_pkg::LANE_Z].p    = WW'(it1_reg.la);
        st0_next.e[vac_pkg::LANE_Z].z    = it1_reg.az2 == '0;
        st0_next.e[vac_pkg::LANE_Z].n    = it1_reg.azn;
        st0_next.v                       = SQW'(it1_reg.la);
    end

    for (genvar k = 0; k < K; k++) begin : g_stage
        localparam int EB = F - k;
        localparam int SB = CB - 1 - k;

        lane_t [vac_pkg::LANES-1:0] e_next;
        logic [SQW-1:0]             v_next;
        logic [SQW-1:0]             res_next;

        if (EB >= 0) begin : g_quo
            // t tracks q*p so each trial is only shifts and one add
            always_comb begin
                logic [WW-1:0] term;
                e_next = st_reg[k].e;
                for (int c = 0; c < vac_pkg::LANES; c++) begin
                    term = ((st_reg[k].e[c].t << 1) + (st_reg[k].e[c].p << EB)) << EB;
                    if (term <= st_reg[k].e[c].r) begin
                        e_next[c].r     = st_reg[k].e[c].r - term;
                        e_next[c].t     = st_reg[k].e[c].t + (st_reg[k].e[c].p << EB);
                        e_next[c].q[EB] = 1'b1;
                    end
                end
            end
        end else begin : g_quo_idle
            assign e_next = st_reg[k].e;
        end

        if (SB >= 0) begin : g_root
            localparam logic [SQW-1:0] RBIT = SQW'(1) << (2 * SB);
            always_comb begin
                v_next   = st_reg[k].v;
                res_next = st_reg[k].res >> 1;
                if (st_reg[k].v >= st_reg[k].res + RBIT) begin
                    v_next   = st_reg[k].v - (st_reg[k].res + RBIT);
                    res_next = (st_reg[k].res >> 1) + RBIT;
                end
            end
        end else begin : g_root_idle
            assign v_next   = st_reg[k].v;
            assign res_next = st_reg[k].res;
        end

        assign st_next[k].e   = e_next;
        assign st_next[k].v   = v_next;
        assign st_next[k].res = res_next;

        always_ff @(posedge aclk) begin
            if (adv) begin
                st_reg[k+1] <= st_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0] <= st0_next;
        end
    end

    // sign, saturation at just under one, zero-length forcing
    always_comb begin
        logic [QW-1:0] q;
        logic [QW-1:0] cs [vac_pkg::LANES];
        for (int c = 0; c < vac_pkg::LANES; c++) begin
            q = st_reg[K].e[c].q;
            if (st_reg[K].e[c].z) begin
                cs[c] = '0;
            end else if (st_reg[K].e[c].n) begin
                cs[c] = ~q + 1'b1;
            end else if (q[QW-1]) begin
                cs[c] = {1'b0, {F{1'b1}}};
            end else begin
                cs[c] = q;
            end
        end
        md_next = MW'({st_reg[K].e[vac_pkg::LANE_BETW].z,
                       st_reg[K].res[CB-1:0],
                       cs[vac_pkg::LANE_Z], cs[vac_pkg::LANE_Y],
                       cs[vac_pkg::LANE_X], cs[vac_pkg::LANE_BETW]});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            md_reg <= md_next;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

endmodule

`default_nettype wire

// ===== design/vac_checker.sv =====
// ----------------------------------------------------------------------------
// vac_checker
// Port-level checks for vector_angle_cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module vac_checker #(
    parameter int COMPONENT_BITS = vac_pkg::COMPONENT_BITS_DEF,
    parameter int FRACTION_BITS  = vac_pkg::FRACTION_BITS_DEF
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic [((6*COMPONENT_BITS+7)/8)*8-1:0] s_tdata,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((4*(FRACTION_BITS+1)+COMPONENT_BITS+1+7)/8)*8-1:0] m_tdata
);

    localparam int QW  = FRACTION_BITS + 1;
    localparam int LPOS = 4 * QW;
    localparam int ZPOS = 4 * QW + COMPONENT_BITS;

    // held word stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_zero_cos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[ZPOS] |-> m_tdata[QW-1:0] == '0)
        else $error("cosine nonzero with zero length flagged");

    // zero length of a forces the flag and all direction cosines to zero
    a_zero_a: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[LPOS +: COMPONENT_BITS] == '0
        |-> m_tdata[ZPOS] && m_tdata[QW +: 3*QW] == '0)
        else $error("zero length a with nonzero direction cosines");

endmodule

bind vector_angle_cosine vac_checker #(
    .COMPONENT_BITS(COMPONENT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
) u_vac_checker (.*);

`default_nettype wire
